// ----- rtl/wsr_pkg.sv -----
// shared types and constants for the windowed-sinc resampler
package wsr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned INDEX_W  = 14;
  localparam int unsigned RATIO_W  = 18;
  localparam int unsigned HALF_W   = 22;
  localparam int unsigned TLEN_W   = 15;
  localparam int unsigned CENTRE_W = 48;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned DIV_W    = 66;

  localparam int unsigned MAX_OUT      = 40;
  localparam int unsigned WEIGHT_FLOOR = 9;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  // register indexes of the configuration port
  localparam logic [1:0] REG_RATIO_STEP   = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH   = 2'd1;
  localparam logic [1:0] REG_TABLE_LENGTH = 2'd2;

  // item kinds carried on tuser
  localparam logic KIND_TABLE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [INDEX_W-1:0]         table_index;
    logic signed [COEF_W-1:0]   table_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } cmd_t;

endpackage

// ----- rtl/wsr_ram.sv -----
// generic single-write, single-read ram with registered read data
module wsr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/wsr_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module wsr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wsr_pkg::DIV_W-1:0] dividend,
  input  logic [wsr_pkg::DIV_W-1:0] divisor,
  output logic [wsr_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import wsr_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(DIV_W - 1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? DIV_W'(rem_sh - {1'b0, dvs}) : DIV_W'(rem_sh);
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// ----- rtl/wsr_front.sv -----
// input side: unpacks requests and queues them for the back end
module wsr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output wsr_pkg::cmd_t        cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_ready
);
  import wsr_pkg::*;

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign in_cmd.kind        = s_axis_tuser;
  assign in_cmd.table_index = s_axis_tdata[13:0];
  assign in_cmd.table_value = s_axis_tdata[31:14];
  assign in_cmd.sample      = s_axis_tdata[47:32];
  assign in_cmd.last        = s_axis_tlast;

  assign s_axis_tready = count != 2'd2;
  assign cmd_valid     = count != 2'd0;
  assign cmd           = fifo[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/wsr_back.sv -----
// back end: table and history stores, tap sequencer, normalizing divide
module wsr_back #(
  parameter int unsigned TABLE_DEPTH            = 16384,
  parameter int unsigned HISTORY_DEPTH          = 64,
  parameter int unsigned TABLE_STEPS_PER_SAMPLE = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wsr_pkg::cmd_t               cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [wsr_pkg::RATIO_W-1:0] ratio_step,
  input  logic [wsr_pkg::HALF_W-1:0]  half_width,
  input  logic [wsr_pkg::TLEN_W-1:0]  table_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_data,
  output logic                        out_last
);
  import wsr_pkg::*;

  localparam int unsigned KA = $clog2(TABLE_DEPTH);
  localparam int unsigned HA = $clog2(HISTORY_DEPTH);
  localparam int unsigned DW = CENTRE_W + 1;
  localparam int unsigned PW = DW + $clog2(TABLE_STEPS_PER_SAMPLE) + 1;
  localparam int unsigned LW = PW - 16;
  localparam int unsigned TW = COUNT_W + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TOTAL = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_RD1   = 4'd4;
  localparam logic [3:0] ST_RD2   = 4'd5;
  localparam logic [3:0] ST_WGT   = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;
  localparam logic [3:0] ST_NORM  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]                 state;
  logic [COUNT_W-1:0]         samples_seen;
  logic [CENTRE_W-1:0]        next_centre;
  logic [COUNT_W-1:0]         outputs_done;
  logic [DIV_W-1:0]           total;
  logic [5:0]                 count;
  logic                       last_item;
  logic                       pass_item;
  logic [TW-1:0]              tap;
  logic [TW-1:0]              tap_last;
  logic [15:0]                frac_q;
  logic [KA-1:0]              lower_q;
  logic                       wvalid;
  logic signed [COEF_W-1:0]   k0;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [35:0]         p0;
  logic signed [35:0]         p1;
  logic signed [36:0]         weight;
  logic signed [52:0]         prod;
  logic signed [63:0]         acc;
  logic signed [63:0]         wacc;
  logic                       neg;
  logic [15:0]                res_data;
  logic                       res_last;
  logic                       div_start;
  logic [DIV_W-1:0]           div_a;
  logic [DIV_W-1:0]           div_b;
  logic [DIV_W-1:0]           div_q;
  logic                       div_done;
  logic                       start_total;
  logic                       start_norm;
  logic                       wsum_small;

  logic                       kram_we;
  logic [KA-1:0]              kram_waddr;
  logic [KA-1:0]              kram_raddr;
  logic [COEF_W-1:0]          kram_rdata;
  logic                       ring_we;
  logic [HA-1:0]              ring_addr_w;
  logic [HA-1:0]              ring_raddr;
  logic [SAMPLE_W-1:0]        ring_rdata;

  // window bounds and tap geometry
  logic [DW-1:0]  centre_x;
  logic [DW-1:0]  reach_hi;
  logic [TW-1:0]  first_t;
  logic [TW-1:0]  last_raw;
  logic [TW-1:0]  last_t;
  logic           stop_now;
  logic [DW-1:0]  tap_pos;
  logic [DW-1:0]  tap_span;
  logic [PW-1:0]  kpos;
  logic [LW-1:0]  lower;
  logic [17:0]    tlen_eff;
  logic           tap_ok;
  logic           is_pass;
  logic [COUNT_W-1:0] seen_inc;
  logic [63:0]    num;
  logic [63:0]    den;
  logic [DIV_W-1:0] od_inc;
  logic           emit_ok;

  assign cmd_ready = state == ST_IDLE;
  assign seen_inc  = samples_seen + 1'b1;
  assign is_pass   = (ratio_step == RATIO_ONE) || (ratio_step == '0) || (table_length == '0);

  assign centre_x = DW'(next_centre);
  assign reach_hi = centre_x + DW'(half_width);
  assign last_raw = TW'(reach_hi >> 16);
  assign first_t  = (centre_x <= DW'(half_width)) ? '0 :
                    TW'((centre_x - DW'(half_width) + DW'(16'hFFFF)) >> 16);
  assign last_t   = (last_raw >= TW'(samples_seen)) ? TW'(samples_seen) - 1'b1 : last_raw;
  assign od_inc   = DIV_W'(outputs_done) + 1'b1;
  assign stop_now = (count == 6'(MAX_OUT)) ||
                    (last_item ? (DIV_W'(outputs_done) >= total)
                               : (last_raw >= TW'(samples_seen)));

  assign tap_pos  = DW'({tap[TW-2:0], 16'h0000});
  assign tap_span = (tap_pos >= centre_x) ? tap_pos - centre_x : centre_x - tap_pos;
  assign kpos     = PW'(tap_span) * PW'(TABLE_STEPS_PER_SAMPLE);
  assign lower    = kpos[PW-1:16];
  assign tlen_eff = (18'(table_length) < 18'(TABLE_DEPTH)) ? 18'(table_length)
                                                            : 18'(TABLE_DEPTH);
  assign tap_ok   = (LW'(lower) + 1'b1) < LW'(tlen_eff);

  assign num = acc[63] ? 64'(-acc) : 64'(acc);
  assign den = wacc[63] ? 64'(-wacc) : 64'(wacc);
  assign wsum_small = (wacc > -64'sd9) && (wacc < 64'sd9);

  assign start_total = (state == ST_IDLE) && cmd_valid && (cmd.kind == KIND_SAMPLE) &&
                       !is_pass && cmd.last;
  assign start_norm  = (state == ST_NORM) && !wsum_small;

  assign kram_we    = (state == ST_IDLE) && cmd_valid && (cmd.kind == KIND_TABLE);
  assign kram_waddr = KA'(32'(cmd.table_index) % TABLE_DEPTH);
  assign kram_raddr = (state == ST_ADDR) ? lower[KA-1:0] : lower_q + 1'b1;
  assign ring_we     = (state == ST_IDLE) && cmd_valid && (cmd.kind == KIND_SAMPLE);
  assign ring_addr_w = HA'(samples_seen % HISTORY_DEPTH);
  assign ring_raddr  = HA'(tap % HISTORY_DEPTH);
  assign emit_ok     = !out_valid || out_ready;

  wsr_ram #(.WIDTH(COEF_W), .DEPTH(TABLE_DEPTH)) u_kernel (
    .clk(clk), .we(kram_we), .waddr(kram_waddr), .wdata(cmd.table_value),
    .raddr(kram_raddr), .rdata(kram_rdata)
  );

  wsr_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_history (
    .clk(clk), .we(ring_we), .waddr(ring_addr_w), .wdata(cmd.sample),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  wsr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .done(div_done)
  );

  // one-cycle start pulse for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= start_total || start_norm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      samples_seen <= '0;
      next_centre  <= '0;
      outputs_done <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == ST_EMIT && emit_ok)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.kind == KIND_SAMPLE) begin
            samples_seen <= seen_inc;
            last_item    <= cmd.last;
            count        <= '0;
            pass_item    <= is_pass;
            if (is_pass) begin
              res_data <= cmd.sample;
              res_last <= cmd.last;
              state    <= ST_EMIT;
            end else if (cmd.last) begin
              div_a     <= (DIV_W'(seen_inc) << 17) + DIV_W'(ratio_step);
              div_b     <= DIV_W'(ratio_step) << 1;
              state     <= ST_TOTAL;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_TOTAL: begin
          if (div_done) begin
            total <= div_q;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          acc      <= '0;
          wacc     <= '0;
          tap      <= first_t;
          tap_last <= last_t;
          if (stop_now) begin
            state <= ST_DONE;
          end else if (samples_seen == '0 || first_t > last_t) begin
            state <= ST_NORM;
          end else begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          lower_q <= lower[KA-1:0];
          frac_q  <= kpos[15:0];
          wvalid  <= tap_ok;
          state   <= ST_RD1;
        end
        ST_RD1: begin
          k0    <= kram_rdata;
          smp   <= ring_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          p0    <= k0 * $signed({1'b0, 17'(17'h10000 - 17'(frac_q))});
          p1    <= $signed(kram_rdata) * $signed({2'b00, frac_q});
          state <= ST_WGT;
        end
        ST_WGT: begin
          weight <= wvalid ? 37'(p0) + 37'(p1) : '0;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= weight * smp;
          wacc  <= wacc + 64'(weight);
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc + 64'(prod);
          if (tap == tap_last) begin
            state <= ST_NORM;
          end else begin
            tap   <= tap + 1'b1;
            state <= ST_ADDR;
          end
        end
        ST_NORM: begin
          res_last <= last_item && ((count + 1'b1 == 6'(MAX_OUT)) || (od_inc >= total));
          if (wsum_small) begin
            res_data <= '0;
            state    <= ST_EMIT;
          end else begin
            neg       <= acc[63] != wacc[63];
            div_a     <= DIV_W'({num, 1'b0}) + DIV_W'(den);
            div_b     <= DIV_W'({den, 1'b0});
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (neg) begin
              res_data <= (div_q > DIV_W'(32768)) ? 16'h8000 : 16'(-div_q[15:0]);
            end else begin
              res_data <= (div_q > DIV_W'(32767)) ? 16'h7FFF : div_q[15:0];
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            out_data  <= res_data;
            out_last  <= res_last;
            if (pass_item) begin
              state <= ST_DONE;
            end else begin
              next_centre  <= next_centre + CENTRE_W'(ratio_step);
              outputs_done <= outputs_done + 1'b1;
              count        <= count + 1'b1;
              state        <= ST_CHECK;
            end
          end
        end
        ST_DONE: begin
          if (last_item) begin
            samples_seen <= '0;
            next_centre  <= '0;
            outputs_done <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/windowed_sinc_resampler_core.sv -----
// top level of the windowed-sinc sample-rate converter
// usage:
//   s_axis carries one request per beat: tuser 0 loads a kernel table entry,
//   tuser 1 delivers an audio sample, tlast marks the final sample of a signal.
//   m_axis returns resampled samples, tlast on the final output of a signal.
//   cfg writes ratio_step (0), half_width (1) and table_length (2); the user
//   must write them only while idle, as the block does no check of this.
// operation:
//   a table load is written in the idle state; a pass-through sample goes
//   straight to the emit step. each output costs a check step, then per tap
//   address, read, weight, multiply and accumulate steps (one shared read port
//   on the kernel ram, two reads per tap, then two multiply stages), then a divide in the
//   shared bit-serial divider, which first gives the final sample's output count.
//   one request is processed at a time; a two-entry queue holds the next ones.
// reset:
//   synchronous rst clears the queue, counters and output register; config
//   registers return to ratio 1.0, half width 8.0, empty table (pass through).
//   the table and history rams are not cleared and must be loaded before use.
// stall:
//   when m_axis_tready is low the output register holds its sample, the back
//   end waits with the next result, and s_axis_tready drops once the queue fills.
module windowed_sinc_resampler_core #(
  parameter int unsigned TABLE_DEPTH            = 16384,
  parameter int unsigned HISTORY_DEPTH          = 64,
  parameter int unsigned TABLE_STEPS_PER_SAMPLE = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // table_index[13:0], table_value[31:14], sample_in[47:32]
  input  logic        s_axis_tuser,   // action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample_out[15:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import wsr_pkg::*;

  // configuration registers
  logic [RATIO_W-1:0] ratio_step;
  logic [HALF_W-1:0]  half_width;
  logic [TLEN_W-1:0]  table_length;

  // request queue between front and back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_step   <= RATIO_ONE;
      half_width   <= HALF_W'(524288);
      table_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RATIO_STEP:   ratio_step   <= cfg_data[RATIO_W-1:0];
        REG_HALF_WIDTH:   half_width   <= cfg_data;
        REG_TABLE_LENGTH: table_length <= cfg_data[TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: unpack and queue requests
  wsr_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  // back: stores, tap walk, normalization, output register
  wsr_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .TABLE_STEPS_PER_SAMPLE(TABLE_STEPS_PER_SAMPLE)
  ) u_back (
    .clk(clk), .rst(rst),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .ratio_step(ratio_step), .half_width(half_width), .table_length(table_length),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast)
  );
endmodule

// ----- rtl/wsr_checker.sv -----
// port-level checks for the resampler core, bound to the top level
module wsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // reset empties the request queue
  a_rst_queue: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("queue not empty after reset");

  // a stalled result keeps its sample and last flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");
endmodule

bind windowed_sinc_resampler_core wsr_checker u_wsr_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
